// File: hdl/parametric_line_clipper_top_assert.svh
// Assertion macros shared by the clipper checker.
`ifndef PARAMETRIC_LINE_CLIPPER_TOP_ASSERT_SVH
`define PARAMETRIC_LINE_CLIPPER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PLC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/plc_pkg.sv
// Package with payload types and constants for the line clipper.
`default_nettype none
package plc_pkg;
    localparam int CoordW = 16;
    localparam int DiffW = 17;
    localparam logic [1:0] RegLeft = 2'd0;
    localparam logic [1:0] RegBottom = 2'd1;
    localparam logic [1:0] RegRight = 2'd2;
    localparam logic [1:0] RegTop = 2'd3;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } seg_in_t;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] clip_start_x;
        logic signed [15:0] clip_start_y;
        logic signed [15:0] clip_end_x;
        logic signed [15:0] clip_end_y;
    } seg_out_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
    } win_t;
endpackage
`default_nettype wire

// File: hdl/plc_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
`default_nettype none
module plc_div #(
    parameter int NumW = 33,
    parameter int DenW = 17,
    parameter int TagW = 1
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [NumW-1:0] num,
    input  wire logic [DenW-1:0] den,
    input  wire logic [TagW-1:0] tag_in,
    output logic      [NumW-1:0] quo,
    output logic      [TagW-1:0] tag_out
);
    logic [NumW-1:0] q_reg   [NumW+1];
    logic [DenW:0]   r_reg   [NumW+1];
    logic [DenW-1:0] d_reg   [NumW+1];
    logic [TagW-1:0] t_reg   [NumW+1];

    always_comb begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        t_reg[0] = tag_in;
    end

    for (genvar k = 0; k < NumW; k++) begin : g_st
        logic [DenW:0]   trial;
        logic [DenW+1:0] diff;
        assign trial = {r_reg[k][DenW-1:0], q_reg[k][NumW-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[DenW+1]) begin
                    r_reg[k+1] <= diff[DenW:0];
                end else begin
                    r_reg[k+1] <= trial;
                end
                q_reg[k+1] <= {q_reg[k][NumW-2:0], ~diff[DenW+1]};
                d_reg[k+1] <= d_reg[k];
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    assign quo     = q_reg[NumW];
    assign tag_out = t_reg[NumW];
endmodule
`default_nettype wire

// File: hdl/parametric_line_clipper_top.sv
// Top level of the pipelined Liang-Barsky line clipper.
//
//  channel  | direction | handshake      | payload
//  s_       | in        | s_valid/ready  | plc_pkg::seg_in_t
//  m_       | out       | m_valid/ready  | plc_pkg::seg_out_t
//  apb      | in        | psel/penable   | window registers 0..3
//
// One segment can enter in every cycle while the output is not stalled; the latency is set
// mostly by the bit-per-stage dividers of the four ratios.
// Reset is synchronous on aresetn and clears all valid bits and the window to its defaults.
// The whole pipeline advances only when its last stage is empty or being taken, so a stall
// holds every stage in place and nothing is lost or repeated.
`default_nettype none
module parametric_line_clipper_top #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire plc_pkg::seg_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output plc_pkg::seg_out_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import plc_pkg::*;

    // Numerator |q| << F is at most 18+F bits; quotient likewise.
    localparam int NumW = DiffW + 1 + PARAM_FRAC_BITS;
    localparam int UW   = PARAM_FRAC_BITS + 1;
    localparam int DivLat = NumW;
    // Tag passed through the dividers: sign, p zero, and q negative.
    localparam int TagW = 3;

    win_t win_reg;
    logic [1:0] reg_idx;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= -16'sd2048;
            win_reg.bottom <= -16'sd2048;
            win_reg.right  <= 16'sd2048;
            win_reg.top    <= 16'sd2048;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                RegLeft:   win_reg.left   <= pwdata[15:0];
                RegBottom: win_reg.bottom <= pwdata[15:0];
                RegRight:  win_reg.right  <= pwdata[15:0];
                RegTop:    win_reg.top    <= pwdata[15:0];
                default:   win_reg.left   <= win_reg.left;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegLeft:   prdata = {{16{win_reg.left[15]}}, win_reg.left};
            RegBottom: prdata = {{16{win_reg.bottom[15]}}, win_reg.bottom};
            RegRight:  prdata = {{16{win_reg.right[15]}}, win_reg.right};
            default:   prdata = {{16{win_reg.top[15]}}, win_reg.top};
        endcase
    end

    // A single enable moves the whole pipeline; the output stage is the last register.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: differences and edge terms.
    logic               v1_reg;
    seg_in_t            in1_reg;
    logic signed [16:0] p1_reg [4];
    logic signed [16:0] q1_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            in1_reg <= s_data;
            p1_reg[0] <= 17'(s_data.start_x) - 17'(s_data.end_x);
            p1_reg[1] <= 17'(s_data.end_x) - 17'(s_data.start_x);
            p1_reg[2] <= 17'(s_data.start_y) - 17'(s_data.end_y);
            p1_reg[3] <= 17'(s_data.end_y) - 17'(s_data.start_y);
            q1_reg[0] <= 17'(s_data.start_x) - 17'(win_reg.left);
            q1_reg[1] <= 17'(win_reg.right) - 17'(s_data.start_x);
            q1_reg[2] <= 17'(s_data.start_y) - 17'(win_reg.bottom);
            q1_reg[3] <= 17'(win_reg.top) - 17'(s_data.start_y);
        end
    end

    // Divider operands: magnitudes with the sign of the quotient on the side.
    logic [NumW-1:0] dnum [4];
    logic [16:0]     dden [4];
    logic [TagW-1:0] dtag [4];
    logic [NumW-1:0] dquo [4];
    logic [TagW-1:0] dtag_o [4];

    for (genvar e = 0; e < 4; e++) begin : g_edge
        logic [16:0] qa;
        assign qa = q1_reg[e][16] ? 17'(-q1_reg[e]) : 17'(q1_reg[e]);
        assign dnum[e] = {{(NumW-17){1'b0}}, qa} << PARAM_FRAC_BITS;
        assign dden[e] = p1_reg[e][16] ? 17'(-p1_reg[e]) : 17'(p1_reg[e]);
        assign dtag[e] = {p1_reg[e][16], p1_reg[e] == 17'sd0, q1_reg[e][16]};
        plc_div #(.NumW(NumW), .DenW(17), .TagW(TagW)) u_div (
            .aclk(aclk), .en(adv), .num(dnum[e]), .den(dden[e]),
            .tag_in(dtag[e]), .quo(dquo[e]), .tag_out(dtag_o[e])
        );
    end

    // Carry the input item and differences alongside the dividers.
    seg_in_t            dly_in  [DivLat];
    logic signed [16:0] dly_dx  [DivLat];
    logic signed [16:0] dly_dy  [DivLat];
    logic               dly_v   [DivLat];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DivLat; k++) dly_v[k] <= 1'b0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg   <= s_valid;
            dly_v[0] <= v1_reg;
            for (int k = 1; k < DivLat; k++) dly_v[k] <= dly_v[k-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_in[0] <= in1_reg;
            dly_dx[0] <= p1_reg[1];
            dly_dy[0] <= p1_reg[3];
            for (int k = 1; k < DivLat; k++) begin
                dly_in[k] <= dly_in[k-1];
                dly_dx[k] <= dly_dx[k-1];
                dly_dy[k] <= dly_dy[k-1];
            end
        end
    end

    // Stage A: u1/u2 reduction. Exit ratios are clamped to 1, which leaves the
    // min with 1 unchanged; entry ratios above 1 are held just above 1 so that
    // they still exceed every exit parameter.
    logic        va_reg;
    logic        keep_a_reg;
    logic [UW-1:0] u1_a_reg, u2_a_reg;
    seg_in_t     in_a_reg;
    logic signed [16:0] dx_a_reg, dy_a_reg;
    logic va_next_keep;
    logic [UW-1:0] u1_a_next, u2_a_next;

    always_comb begin
        logic [UW-1:0] one;
        logic [UW-1:0] rc;
        logic [UW-1:0] rc_in;
        logic [UW-1:0] u1n, u2n;
        logic          kp;
        one = UW'(1) << PARAM_FRAC_BITS;
        u1n = '0;
        u2n = one;
        kp  = 1'b1;
        for (int e = 0; e < 4; e++) begin
            // tag: [2] p negative, [1] p zero, [0] q negative
            rc    = (dquo[e] > NumW'(one)) ? one : dquo[e][UW-1:0];
            rc_in = (dquo[e] > NumW'(one)) ? one + UW'(1) : dquo[e][UW-1:0];
            if (dtag_o[e][1]) begin
                if (dtag_o[e][0]) kp = 1'b0;
            end else if (dtag_o[e][2]) begin
                // p<0: r = q/p, positive when q negative
                if (dtag_o[e][0] && dquo[e] != '0 && rc_in > u1n) u1n = rc_in;
            end else begin
                // p>0: r negative when q negative, forcing u2 below u1
                if (dtag_o[e][0]) begin
                    if (dquo[e] != '0) kp = 1'b0;
                    else if (rc < u2n) u2n = '0;
                end else if (rc < u2n) u2n = rc;
            end
        end
        va_next_keep = kp && (u1n <= u2n);
        u1_a_next = u1n;
        u2_a_next = u2n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) va_reg <= 1'b0;
        else if (adv) va_reg <= dly_v[DivLat-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            keep_a_reg <= va_next_keep;
            u1_a_reg <= u1_a_next;
            u2_a_reg <= u2_a_next;
            in_a_reg <= dly_in[DivLat-1];
            dx_a_reg <= dly_dx[DivLat-1];
            dy_a_reg <= dly_dy[DivLat-1];
        end
    end

    // Stage B: products u*d.
    localparam int PW = UW + 1 + 17;
    logic        vb_reg, keep_b_reg;
    seg_in_t     in_b_reg;
    logic signed [PW-1:0] pr_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) vb_reg <= 1'b0;
        else if (adv) vb_reg <= va_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            keep_b_reg <= keep_a_reg;
            in_b_reg <= in_a_reg;
            pr_reg[0] <= PW'($signed({1'b0, u1_a_reg}) * dx_a_reg);
            pr_reg[1] <= PW'($signed({1'b0, u1_a_reg}) * dy_a_reg);
            pr_reg[2] <= PW'($signed({1'b0, u2_a_reg}) * dx_a_reg);
            pr_reg[3] <= PW'($signed({1'b0, u2_a_reg}) * dy_a_reg);
        end
    end

    // Stage C: round and add start point, select output.
    logic signed [PW-1:0] rnd [4];
    logic signed [15:0]   pt  [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (pr_reg[k] + (PW'(1) << (PARAM_FRAC_BITS - 1))) >>> PARAM_FRAC_BITS;
        end
        pt[0] = 16'(in_b_reg.start_x + rnd[0][15:0]);
        pt[1] = 16'(in_b_reg.start_y + rnd[1][15:0]);
        pt[2] = 16'(in_b_reg.start_x + rnd[2][15:0]);
        pt[3] = 16'(in_b_reg.start_y + rnd[3][15:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (adv) m_valid <= vb_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data.visible <= keep_b_reg;
            if (keep_b_reg) begin
                m_data.clip_start_x <= pt[0];
                m_data.clip_start_y <= pt[1];
                m_data.clip_end_x   <= pt[2];
                m_data.clip_end_y   <= pt[3];
            end else begin
                m_data.clip_start_x <= in_b_reg.start_x;
                m_data.clip_start_y <= in_b_reg.start_y;
                m_data.clip_end_x   <= in_b_reg.end_x;
                m_data.clip_end_y   <= in_b_reg.end_y;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/plc_checker.sv
// Port-level checker for the line clipper, bound to the top level.
`default_nettype none
`include "parametric_line_clipper_top_assert.svh"
module plc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic pready,
    input wire logic [64:0] m_data
);
    `PLC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `PLC_ASSERT_IMP(a_ready, aclk, aresetn, !m_valid, s_ready)
    `PLC_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready)
    `PLC_ASSERT_IMP(a_stall, aclk, aresetn, m_valid && !m_ready, !s_ready)
endmodule
bind parametric_line_clipper_top plc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .pready(pready), .m_data(m_data)
);
`default_nettype wire

// File: tb/parametric_line_clipper_top_tb.sv
// Self-checking testbench for the pipelined Liang-Barsky line clipper.
`default_nettype none
module parametric_line_clipper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    // The predictor below is written for this fraction width.
    localparam int FracBits = 16;
    // Rough pipeline depth, plus some margin.
    localparam int PipeLatency = FracBits + 21;
    localparam int SettleCycles = PipeLatency + 10;
    // Worst correct gap: a full pipeline draining through receiver stalls.
    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    seg_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    seg_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Testbench copy of the window registers.
    win_t       window_copy;
    seg_out_t   clipped_queue[$];
    int         fail_count = 0;
    int         idle_cycles = 0;
    bit         random_idling = 1'b0;
    bit         hold_receiver = 1'b0;

    always #6 aclk = ~aclk;

    parametric_line_clipper_top #(.PARAM_FRAC_BITS(FracBits)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Edge interpolation: start + round(u * d / 2^F), ties towards plus infinity.
    function automatic logic signed [15:0] interpolate(longint s, longint u, longint d);
        longint prod;
        longint rounded;
        prod = u * d + (longint'(1) << (FracBits - 1));
        rounded = prod >>> FracBits;
        return 16'(s + rounded);
    endfunction

    // Liang-Barsky clip of one segment against the current window copy.
    function automatic seg_out_t clip_segment(seg_in_t seg);
        seg_out_t res;
        longint sx, sy, dx, dy, r, u_entry, u_exit;
        longint p[4];
        longint q[4];
        bit kept;
        sx = seg.start_x;
        sy = seg.start_y;
        dx = longint'(seg.end_x) - sx;
        dy = longint'(seg.end_y) - sy;
        p[0] = -dx; q[0] = sx - window_copy.left;
        p[1] = dx;  q[1] = longint'(window_copy.right) - sx;
        p[2] = -dy; q[2] = sy - window_copy.bottom;
        p[3] = dy;  q[3] = longint'(window_copy.top) - sy;
        u_entry = 0;
        u_exit = longint'(1) << FracBits;
        kept = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (p[i] == 0) begin
                if (q[i] < 0) kept = 1'b0;
            end else begin
                // SystemVerilog division truncates towards zero.
                r = (q[i] * (longint'(1) << FracBits)) / p[i];
                if (p[i] < 0) begin
                    if (r > u_entry) u_entry = r;
                end else if (r < u_exit) begin
                    u_exit = r;
                end
            end
        end
        if (u_entry > u_exit) kept = 1'b0;
        if (kept) begin
            res.visible = 1'b1;
            res.clip_start_x = interpolate(sx, u_entry, dx);
            res.clip_start_y = interpolate(sy, u_entry, dy);
            res.clip_end_x = interpolate(sx, u_exit, dx);
            res.clip_end_y = interpolate(sy, u_exit, dy);
        end else begin
            res.visible = 1'b0;
            res.clip_start_x = seg.start_x;
            res.clip_start_y = seg.start_y;
            res.clip_end_x = seg.end_x;
            res.clip_end_y = seg.end_y;
        end
        return res;
    endfunction

    // Offers one segment from the next falling edge (later after a random idle gap
    // when idling is on) and holds it until the transfer happens; valid stays high
    // afterwards until the next segment or the next drain takes it over.
    task automatic send_segment(seg_in_t seg);
        @(negedge aclk);
        if (random_idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= seg;
        do @(posedge aclk); while (!s_ready);
        clipped_queue.push_back(clip_segment(seg));
    endtask

    task automatic send_coords(int sx, int sy, int ex, int ey);
        seg_in_t seg;
        seg.start_x = 16'(sx);
        seg.start_y = 16'(sy);
        seg.end_x = 16'(ex);
        seg.end_y = 16'(ey);
        send_segment(seg);
    endtask

    // Waits until every expected result has arrived, then lets the pipeline settle.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (clipped_queue.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_register(logic [1:0] index, logic signed [15:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {{16{value[15]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            RegLeft:   window_copy.left = value;
            RegBottom: window_copy.bottom = value;
            RegRight:  window_copy.right = value;
            default:   window_copy.top = value;
        endcase
    endtask

    task automatic set_window(int left, int bottom, int right, int top);
        write_register(RegLeft, 16'(left));
        write_register(RegBottom, 16'(bottom));
        write_register(RegRight, 16'(right));
        write_register(RegTop, 16'(top));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return int'($urandom_range(0, 8192)) - 4096;
            2: return window_copy.left + int'($urandom_range(0, 2)) - 1;
            3: return window_copy.top + int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Directed cases under the reset window: extremes and the special cases.
    task automatic test_directed_reset_window();
        send_coords(-4096, 0, 4096, 0);          // crosses left and right
        send_coords(0, -4096, 0, 4096);          // vertical, crosses bottom and top
        send_coords(-1000, -1000, 1000, 1000);   // fully inside
        send_coords(3000, 3000, 4000, 4000);     // fully outside, entry beyond exit
        send_coords(0, 3000, 100, 3000);         // parallel to top, outside
        send_coords(100, 100, 100, 100);         // point inside
        send_coords(2048, 2048, 2048, 2048);     // point on corner
        send_coords(2049, 0, 2049, 0);           // point just outside
        send_coords(-32768, -32768, 32767, 32767);
        send_coords(32767, -32768, -32768, 32767);
        send_coords(-32768, 0, 32767, 0);
        send_coords(2048, -4096, 2048, 4096);    // on the right edge
        send_coords(-4096, 4096, 4096, -4096);   // through corners, equal parameters
        send_coords(-4096, 0, 0, 4096);          // touches corner at a single point
        send_coords(32767, 32767, -32768, -32768);
        send_coords(-1, -1, 0, 0);
        drain_pipeline();
    endtask

    // Extreme and inverted windows.
    task automatic test_window_extremes();
        set_window(-32768, -32768, 32767, 32767);
        send_coords(-32768, -32768, 32767, 32767);
        send_coords(32767, 0, -32768, 1);
        send_coords(5, 5, 5, 5);
        drain_pipeline();
        set_window(100, 100, -100, -100);
        send_coords(0, 0, 0, 0);
        send_coords(-32768, -32768, 32767, 32767);
        drain_pipeline();
        set_window(0, 0, 0, 0);
        send_coords(-5, 0, 5, 0);
        send_coords(0, 0, 0, 0);
        drain_pipeline();
    endtask

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) send_coords(rand_coord(), rand_coord(),
                                                    rand_coord(), rand_coord());
    endtask

    // Random segments under several random windows, with idling on both sides.
    task automatic test_random_windows();
        int a, b, c, d;
        random_idling = 1'b1;
        for (int w = 0; w < 6; w++) begin
            a = int'($urandom_range(0, 16384)) - 12288;
            b = int'($urandom_range(0, 16384)) - 12288;
            c = a + int'($urandom_range(0, 20000));
            d = b + int'($urandom_range(0, 20000));
            set_window(a, b, c > 32767 ? 32767 : c, d > 32767 ? 32767 : d);
            random_burst(200);
            drain_pipeline();
        end
    endtask

    // Long receiver hold-off so the pipeline fills and back-pressures the input.
    task automatic test_backpressure();
        set_window(-2048, -2048, 2048, 2048);
        random_idling = 1'b0;
        hold_receiver = 1'b1;
        fork
            begin
                repeat (3 * PipeLatency) @(negedge aclk);
                hold_receiver = 1'b0;
            end
            random_burst(150);
        join
        drain_pipeline();
    endtask

    // Final stretch with no idling on either side.
    task automatic test_full_rate();
        set_window(-4096, -3000, 3000, 4096);
        random_idling = 1'b0;
        random_burst(130);
        drain_pipeline();
    endtask

    // Receiver: random stall bursts, or a forced hold-off.
    always @(negedge aclk) begin
        if (!aresetn || hold_receiver) begin
            m_ready <= 1'b0;
        end else if (random_idling && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Checks every result transfer against the oldest expectation.
    always @(posedge aclk) begin
        seg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (clipped_queue.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = clipped_queue.pop_front();
                if (m_data.visible !== want.visible) begin
                    $error("visible: expected %0d, got %0d", want.visible, m_data.visible);
                    fail_count++;
                end
                if (m_data.clip_start_x !== want.clip_start_x) begin
                    $error("clip_start_x: expected %0d, got %0d",
                           want.clip_start_x, m_data.clip_start_x);
                    fail_count++;
                end
                if (m_data.clip_start_y !== want.clip_start_y) begin
                    $error("clip_start_y: expected %0d, got %0d",
                           want.clip_start_y, m_data.clip_start_y);
                    fail_count++;
                end
                if (m_data.clip_end_x !== want.clip_end_x) begin
                    $error("clip_end_x: expected %0d, got %0d",
                           want.clip_end_x, m_data.clip_end_x);
                    fail_count++;
                end
                if (m_data.clip_end_y !== want.clip_end_y) begin
                    $error("clip_end_y: expected %0d, got %0d",
                           want.clip_end_y, m_data.clip_end_y);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts consecutive cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        window_copy.left = -16'sd2048;
        window_copy.bottom = -16'sd2048;
        window_copy.right = 16'sd2048;
        window_copy.top = 16'sd2048;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_reset_window();
        test_window_extremes();
        test_random_windows();
        test_backpressure();
        test_full_rate();
        if (fail_count == 0 && clipped_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
